/* rtl/core/pfa_pkg.sv */
// ----------------------------------------------------------------------------
// pfa_pkg: page frame allocator shared definitions
// Sizes, request and status codes, and the controller/datapath link types.
// ----------------------------------------------------------------------------
package pfa_pkg;

	localparam int MAX_PAGES  = 1024;
	localparam int PAGE_BYTES = 4096;

	localparam int IDX_W = $clog2(MAX_PAGES);
	localparam int CNT_W = $clog2(MAX_PAGES + 1);
	localparam int OFF_W = $clog2(PAGE_BYTES);

	localparam int CFG_W  = 11;
	localparam int ADDR_W = 32;

	localparam logic [CFG_W-1:0] TOTAL_RESET    = CFG_W'(1024);
	localparam logic [CFG_W-1:0] RESERVED_RESET = '0;

	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_INIT  = 2'd2
	} op_e;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_REJECT = 2'd2
	} status_e;

	typedef enum logic [1:0] {
		REG_TOTAL    = 2'd0,
		REG_RESERVED = 2'd1
	} reg_idx_e;

	// controller -> datapath
	typedef struct packed {
		logic    latch;     // capture request word
		logic    q_rd;      // read queue head
		logic    mark_rd;   // read mark of freed page
		logic    pop;       // commit allocate
		logic    push_try;  // finish free using mark just read
		logic    init_go;   // reset queue pointers, start sweep
		logic    sweep;     // one sweep step
		logic    reply;     // plain reply
		status_e reply_status;
	} pfa_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [1:0] op;
		logic       empty;
		logic       free_ok;
		logic       sweep_last;
	} pfa_stat_t;

	function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] p);
		logic [IDX_W-1:0] n;
		n = (p == IDX_W'(MAX_PAGES - 1)) ? '0 : p + IDX_W'(1);
		return n;
	endfunction

	function automatic logic [ADDR_W-1:0] page_to_addr(input logic [IDX_W-1:0] idx);
		logic [63:0] w;
		w = 64'(idx) << OFF_W;
		return w[ADDR_W-1:0];
	endfunction

endpackage

/* rtl/core/pfa_ctrl.sv */
// ----------------------------------------------------------------------------
// pfa_ctrl: request sequencer
// Steps each request through decode and then, as the request needs, a memory read and write-back or a sweep.
// ----------------------------------------------------------------------------
module pfa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  pfa_pkg::pfa_stat_t stat,
	output pfa_pkg::pfa_cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_ALLOC_WB,
		S_FREE_WB,
		S_SWEEP
	} state_t;

	state_t state_q;
	state_t state_d;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd              = '0;
		cmd.reply_status = pfa_pkg::ST_OK;
		state_d          = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					state_d   = S_EXEC;
				end
			end
			S_EXEC: begin
				unique case (stat.op)
					pfa_pkg::OP_ALLOC: begin
						if (stat.empty) begin
							cmd.reply        = 1'b1;
							cmd.reply_status = pfa_pkg::ST_EMPTY;
							state_d          = S_IDLE;
						end else begin
							cmd.q_rd = 1'b1;
							state_d  = S_ALLOC_WB;
						end
					end
					pfa_pkg::OP_FREE: begin
						if (!stat.free_ok) begin
							cmd.reply        = 1'b1;
							cmd.reply_status = pfa_pkg::ST_REJECT;
							state_d          = S_IDLE;
						end else begin
							cmd.mark_rd = 1'b1;
							state_d     = S_FREE_WB;
						end
					end
					pfa_pkg::OP_INIT: begin
						cmd.init_go = 1'b1;
						state_d     = S_SWEEP;
					end
					default: begin
						// unused opcode: plain acknowledge
						cmd.reply = 1'b1;
						state_d   = S_IDLE;
					end
				endcase
			end
			S_ALLOC_WB: begin
				cmd.pop = 1'b1;
				state_d = S_IDLE;
			end
			S_FREE_WB: begin
				cmd.push_try = 1'b1;
				state_d      = S_IDLE;
			end
			S_SWEEP: begin
				cmd.sweep = 1'b1;
				if (stat.sweep_last) begin
					cmd.reply = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* rtl/core/pfa_datapath.sv */
// ----------------------------------------------------------------------------
// pfa_datapath: free queue, allocation marks and result registers
// Holds configuration, queue pointers, both memories and the reply word.
// ----------------------------------------------------------------------------
module pfa_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  pfa_pkg::pfa_cmd_t           cmd,
	output pfa_pkg::pfa_stat_t          stat,
	input  logic [1:0]                  op,
	input  logic [pfa_pkg::ADDR_W-1:0]  page_address,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [1:0]                  cfg_index,
	input  logic [pfa_pkg::CFG_W-1:0]   cfg_data,
	output logic                        done,
	output logic [pfa_pkg::ADDR_W-1:0]  granted_address,
	output logic [1:0]                  status,
	output logic [pfa_pkg::CFG_W-1:0]   free_count
);

	localparam int IDX_W = pfa_pkg::IDX_W;
	localparam int CNT_W = pfa_pkg::CNT_W;

	logic [pfa_pkg::CFG_W-1:0]  total_q;
	logic [pfa_pkg::CFG_W-1:0]  reserved_q;
	logic [1:0]                 op_q;
	logic [pfa_pkg::ADDR_W-1:0] addr_q;
	logic [IDX_W-1:0]           head_q;
	logic [IDX_W-1:0]           tail_q;
	logic [CNT_W-1:0]           count_q;
	logic [IDX_W-1:0]           sweep_q;
	logic                       inited_q;
	logic                       done_q;
	logic [pfa_pkg::ADDR_W-1:0] granted_q;
	pfa_pkg::status_e           status_q;

	logic [IDX_W-1:0] q_mem [pfa_pkg::MAX_PAGES];
	logic             mark_mem [pfa_pkg::MAX_PAGES];
	logic [IDX_W-1:0] q_rdata_q;
	logic             mark_rdata_q;

	logic [CNT_W-1:0]           eff_total;
	logic [CNT_W-1:0]           eff_reserved;
	logic [pfa_pkg::ADDR_W-1:0] page_idx;
	logic [IDX_W-1:0]           free_idx;
	logic                       push_ok;
	logic [CNT_W-1:0]           sweep_w;
	logic [CNT_W-1:0]           init_len;

	logic             mark_we;
	logic [IDX_W-1:0] mark_wa;
	logic             mark_wd;
	logic             q_we;
	logic [IDX_W-1:0] q_wa;
	logic [IDX_W-1:0] q_wd;

	assign cfg_ready = 1'b1;

	always_comb begin
		eff_total = (32'(total_q) > 32'(pfa_pkg::MAX_PAGES)) ?
			CNT_W'(pfa_pkg::MAX_PAGES) : CNT_W'(total_q);
		eff_reserved = (32'(reserved_q) > 32'(eff_total)) ? eff_total : CNT_W'(reserved_q);
	end

	assign page_idx = addr_q >> pfa_pkg::OFF_W;
	assign free_idx = page_idx[IDX_W-1:0];
	assign sweep_w  = CNT_W'(sweep_q);
	assign init_len = eff_total - eff_reserved;
	assign push_ok  = inited_q && mark_rdata_q;

	assign stat.op         = op_q;
	assign stat.empty      = (count_q == '0);
	assign stat.free_ok    = (page_idx < 32'(eff_total)) && (page_idx >= 32'(eff_reserved))
		&& (32'(count_q) < 32'(pfa_pkg::MAX_PAGES));
	assign stat.sweep_last = (sweep_q == IDX_W'(pfa_pkg::MAX_PAGES - 1));

	// one write port per memory: sweep, pop and push never overlap
	always_comb begin
		mark_we = 1'b0;
		mark_wa = free_idx;
		mark_wd = 1'b0;
		q_we    = 1'b0;
		q_wa    = tail_q;
		q_wd    = free_idx;
		priority if (cmd.sweep) begin
			mark_we = 1'b1;
			mark_wa = sweep_q;
			mark_wd = (sweep_w < eff_reserved);
			q_we    = (sweep_w >= eff_reserved) && (sweep_w < eff_total);
			q_wa    = IDX_W'(sweep_w - eff_reserved);
			q_wd    = sweep_q;
		end else if (cmd.pop) begin
			mark_we = 1'b1;
			mark_wa = q_rdata_q;
			mark_wd = 1'b1;
		end else if (cmd.push_try) begin
			mark_we = push_ok;
			q_we    = push_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (q_we) begin
			q_mem[q_wa] <= q_wd;
		end
		if (cmd.q_rd) begin
			q_rdata_q <= q_mem[head_q];
		end
	end

	always_ff @(posedge clk) begin
		if (mark_we) begin
			mark_mem[mark_wa] <= mark_wd;
		end
		if (cmd.mark_rd) begin
			mark_rdata_q <= mark_mem[free_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q   <= op;
			addr_q <= page_address;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q    <= pfa_pkg::TOTAL_RESET;
			reserved_q <= pfa_pkg::RESERVED_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == pfa_pkg::REG_TOTAL) begin
				total_q <= cfg_data;
			end else if (cfg_index == pfa_pkg::REG_RESERVED) begin
				reserved_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			tail_q    <= '0;
			count_q   <= '0;
			sweep_q   <= '0;
			inited_q  <= 1'b0;
			done_q    <= 1'b0;
			granted_q <= '0;
			status_q  <= pfa_pkg::ST_OK;
		end else begin
			done_q <= cmd.reply || cmd.pop || cmd.push_try;
			if (cmd.init_go) begin
				head_q   <= '0;
				tail_q   <= (init_len == CNT_W'(pfa_pkg::MAX_PAGES)) ? '0 : IDX_W'(init_len);
				count_q  <= init_len;
				sweep_q  <= '0;
				inited_q <= 1'b1;
			end
			if (cmd.sweep) begin
				sweep_q <= pfa_pkg::next_slot(sweep_q);
			end
			if (cmd.reply) begin
				granted_q <= '0;
				status_q  <= cmd.reply_status;
			end
			if (cmd.pop) begin
				granted_q <= pfa_pkg::page_to_addr(q_rdata_q);
				status_q  <= pfa_pkg::ST_OK;
				head_q    <= pfa_pkg::next_slot(head_q);
				count_q   <= count_q - CNT_W'(1);
			end
			if (cmd.push_try) begin
				granted_q <= '0;
				if (push_ok) begin
					status_q <= pfa_pkg::ST_OK;
					tail_q   <= pfa_pkg::next_slot(tail_q);
					count_q  <= count_q + CNT_W'(1);
				end else begin
					status_q <= pfa_pkg::ST_REJECT;
				end
			end
		end
	end

	assign done            = done_q;
	assign granted_address = granted_q;
	assign status          = status_q;
	assign free_count      = pfa_pkg::CFG_W'(count_q);

endmodule

/* rtl/core/page_frame_free_list_allocator_top.sv */
// ----------------------------------------------------------------------------
// page_frame_free_list_allocator_top: physical page frame allocator
// FIFO free list of page indices with per-page allocation marks.
// ----------------------------------------------------------------------------
// Requests: op and page_address are taken on a clock edge where start is high
//   and busy is low; busy stays high until the cycle the reply is shown.
// Replies: done is high for one cycle with granted_address, status and
//   free_count. The receiver cannot stall and the word is not held.
// Sequence from acceptance to done: allocate and a free that passes the
//   range and queue-full checks go through decode, registered memory read and
//   write-back; an empty allocate, a free that fails those checks and the
//   unused opcode reply from decode; reinitialize sweeps all MAX_PAGES slots,
//   rewriting one page slot of both memories per cycle. Busy drops with done,
//   so requests go one at a time.
// Configuration: cfg_valid/cfg_ready with cfg_index (0 total pages,
//   1 reserved pages) and cfg_data; write only while the block is idle.
// Reset: total pages 1024, reserved 0, queue empty, every free rejected; the
//   memories hold no valid contents until the first reinitialize sweep.
// ----------------------------------------------------------------------------
module page_frame_free_list_allocator_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [1:0]                 op,
	input  logic [pfa_pkg::ADDR_W-1:0] page_address,
	output logic                       done,
	output logic [pfa_pkg::ADDR_W-1:0] granted_address,
	output logic [1:0]                 status,
	output logic [pfa_pkg::CFG_W-1:0]  free_count,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [1:0]                 cfg_index,
	input  logic [pfa_pkg::CFG_W-1:0]  cfg_data
);

	pfa_pkg::pfa_cmd_t  cmd;
	pfa_pkg::pfa_stat_t stat;

	pfa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	pfa_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.op              (op),
		.page_address    (page_address),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.done            (done),
		.granted_address (granted_address),
		.status          (status),
		.free_count      (free_count)
	);

endmodule

/* rtl/core/pfa_checker.sv */
// ----------------------------------------------------------------------------
// pfa_checker: port-level checks for the page frame allocator
// Watches request/reply ordering and reply word consistency.
// ----------------------------------------------------------------------------
module pfa_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       start,
	input logic                       busy,
	input logic                       done,
	input logic [pfa_pkg::ADDR_W-1:0] granted_address,
	input logic [1:0]                 status,
	input logic [pfa_pkg::CFG_W-1:0]  free_count
);

	// a reply only ever closes a request in flight
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("reply word without a pending request");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted request did not raise busy");

	a_no_addr_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != pfa_pkg::ST_OK) |-> (granted_address == '0))
		else $error("address granted on a failed request");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == pfa_pkg::ST_EMPTY) |-> (free_count == '0))
		else $error("empty reported with pages in the free queue");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == pfa_pkg::ST_OK || status == pfa_pkg::ST_EMPTY ||
			status == pfa_pkg::ST_REJECT))
		else $error("unknown status code in reply");

endmodule

bind page_frame_free_list_allocator_top pfa_checker u_pfa_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.start           (start),
	.busy            (busy),
	.done            (done),
	.granted_address (granted_address),
	.status          (status),
	.free_count      (free_count)
);

/* tb/tb_page_frame_free_list_allocator_top.sv */
// ----------------------------------------------------------------------------
// tb_page_frame_free_list_allocator_top: page frame allocator testbench
// A table of directed requests runs from reset, then configuration phases
// with random allocate, free, reinitialize and unused-opcode traffic. A
// software copy of the free queue and allocation marks predicts each reply
// the table does not fix. Replies are checked in order as done strobes arrive.
// ----------------------------------------------------------------------------
module tb_page_frame_free_list_allocator_top;
	timeunit 1ns;
	timeprecision 1ps;

	import pfa_pkg::*;

	localparam logic [1:0] OP_UNUSED   = 2'd3;
	localparam int         STALL_LIMIT = 4000;

	typedef struct {
		logic [ADDR_W-1:0] addr;
		status_e           st;
		logic [CFG_W-1:0]  cnt;
	} page_reply_t;

	typedef struct {
		logic [1:0]        op;
		logic [ADDR_W-1:0] addr;
		bit                fixed;
		logic [ADDR_W-1:0] g_addr;
		status_e           g_st;
		logic [CFG_W-1:0]  g_cnt;
	} stim_row_t;

	typedef struct {
		logic [CFG_W-1:0] total;
		logic [CFG_W-1:0] reserved;
		bit               reinit;
		bit               steady;
		int               items;
	} phase_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [1:0]           op;
	logic [ADDR_W-1:0]    page_address;
	logic                 done;
	logic [ADDR_W-1:0]    granted_address;
	logic [1:0]           status;
	logic [CFG_W-1:0]     free_count;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [1:0]           cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	// allocator image
	logic [IDX_W-1:0]     queue_image[$];
	bit                   page_marks[MAX_PAGES];
	logic [CFG_W-1:0]     total_reg;
	logic [CFG_W-1:0]     reserved_reg;

	logic [IDX_W-1:0]     held_pages[$];
	page_reply_t          expected_replies[$];
	int                   mismatch_count = 0;
	int                   stall_cycles = 0;
	bit                   steady_run = 1'b0;

	stim_row_t directed_rows [18] = '{
		'{OP_ALLOC,  32'h0000_0000, 1'b1, 32'h0000_0000, ST_EMPTY,  11'd0},
		'{OP_FREE,   32'h0000_0000, 1'b1, 32'h0000_0000, ST_REJECT, 11'd0},
		'{OP_UNUSED, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, ST_OK,     11'd0},
		'{OP_INIT,   32'h0000_0000, 1'b1, 32'h0000_0000, ST_OK,     11'd1024},
		'{OP_ALLOC,  32'h0000_0000, 1'b1, 32'h0000_0000, ST_OK,     11'd1023},
		'{OP_ALLOC,  32'h0000_0000, 1'b1, 32'h0000_1000, ST_OK,     11'd1022},
		'{OP_ALLOC,  32'h0000_0000, 1'b1, 32'h0000_2000, ST_OK,     11'd1021},
		// offset bits are dropped
		'{OP_FREE,   32'h0000_1FFF, 1'b1, 32'h0000_0000, ST_OK,     11'd1022},
		'{OP_FREE,   32'h0000_1000, 1'b1, 32'h0000_0000, ST_REJECT, 11'd1022},
		'{OP_FREE,   32'hFFFF_FFFF, 1'b1, 32'h0000_0000, ST_REJECT, 11'd1022},
		// first index past the last page
		'{OP_FREE,   32'h0040_0000, 1'b1, 32'h0000_0000, ST_REJECT, 11'd1022},
		'{OP_FREE,   32'h003F_F000, 1'b1, 32'h0000_0000, ST_REJECT, 11'd1022},
		'{OP_FREE,   32'h0000_0000, 1'b1, 32'h0000_0000, ST_OK,     11'd1023},
		'{OP_UNUSED, 32'h8000_0000, 1'b1, 32'h0000_0000, ST_OK,     11'd1023},
		'{OP_ALLOC,  32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK,     11'd0},
		'{OP_FREE,   32'h0000_2ABC, 1'b0, 32'h0000_0000, ST_OK,     11'd0},
		'{OP_INIT,   32'h5555_AAAA, 1'b1, 32'h0000_0000, ST_OK,     11'd1024},
		'{OP_ALLOC,  32'hFFFF_FFFF, 1'b1, 32'h0000_0000, ST_OK,     11'd1023}
	};

	// phases without reinit keep the old queue but check frees against new limits
	phase_t phases [10] = '{
		'{11'd6,    11'd2,    1'b1, 1'b0, 60},
		'{11'd2047, 11'd0,    1'b1, 1'b0, 40},
		'{11'd0,    11'd0,    1'b1, 1'b0, 20},
		'{11'd20,   11'd2047, 1'b1, 1'b0, 20},
		'{11'd16,   11'd4,    1'b1, 1'b0, 100},
		'{11'd10,   11'd7,    1'b0, 1'b0, 40},
		'{11'd1024, 11'd1024, 1'b0, 1'b0, 30},
		'{11'd1,    11'd0,    1'b1, 1'b0, 30},
		'{11'd40,   11'd3,    1'b1, 1'b1, 150},
		'{11'd1024, 11'd0,    1'b1, 1'b0, 100}
	};

	page_frame_free_list_allocator_top u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.op              (op),
		.page_address    (page_address),
		.done            (done),
		.granted_address (granted_address),
		.status          (status),
		.free_count      (free_count),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [CFG_W-1:0] usable_pages();
		return (total_reg > CFG_W'(MAX_PAGES)) ? CFG_W'(MAX_PAGES) : total_reg;
	endfunction

	function automatic logic [CFG_W-1:0] reserved_limit();
		logic [CFG_W-1:0] lim;
		lim = usable_pages();
		return (reserved_reg > lim) ? lim : reserved_reg;
	endfunction

	function automatic page_reply_t predict_page_reply(input logic [1:0] req_op,
			input logic [ADDR_W-1:0] req_addr);
		page_reply_t              rep;
		logic [ADDR_W-OFF_W-1:0]  idx;
		logic [IDX_W-1:0]         head;
		int                       lo;
		int                       hi;
		rep.addr = '0;
		rep.st   = ST_OK;
		case (req_op)
			OP_ALLOC: begin
				if (queue_image.size() == 0) begin
					rep.st = ST_EMPTY;
				end else begin
					head = queue_image.pop_front();
					page_marks[head] = 1'b1;
					rep.addr = ADDR_W'(head) << OFF_W;
				end
			end
			OP_FREE: begin
				idx = req_addr >> OFF_W;
				if (idx >= usable_pages() || idx < reserved_limit() ||
						!page_marks[idx[IDX_W-1:0]] || queue_image.size() >= MAX_PAGES) begin
					rep.st = ST_REJECT;
				end else begin
					page_marks[idx[IDX_W-1:0]] = 1'b0;
					queue_image.push_back(idx[IDX_W-1:0]);
				end
			end
			OP_INIT: begin
				lo = int'(reserved_limit());
				hi = int'(usable_pages());
				queue_image.delete();
				for (int pg = 0; pg < MAX_PAGES; pg++)
					page_marks[pg] = (pg < lo);
				for (int pg = lo; pg < hi; pg++)
					queue_image.push_back(IDX_W'(pg));
			end
			default: ;
		endcase
		rep.cnt = CFG_W'(queue_image.size());
		return rep;
	endfunction

	// leaves start high after acceptance; the caller lowers it when going quiet
	task automatic send_request(input logic [1:0] req_op, input logic [ADDR_W-1:0] req_addr,
			input bit fixed, input page_reply_t fixed_reply);
		page_reply_t      pred;
		logic [IDX_W-1:0] pg;
		while (!steady_run && $urandom_range(99) < 13) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start        <= 1'b1;
		op           <= req_op;
		page_address <= req_addr;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pred = predict_page_reply(req_op, req_addr);
		expected_replies.push_back(fixed ? fixed_reply : pred);
		if (req_op == OP_ALLOC && pred.st == ST_OK) begin
			held_pages.push_back(pred.addr[OFF_W +: IDX_W]);
		end else if (req_op == OP_FREE && pred.st == ST_OK) begin
			pg = req_addr[OFF_W +: IDX_W];
			held_pages = held_pages.find(p) with (p != pg);
		end else if (req_op == OP_INIT) begin
			held_pages.delete();
		end
	endtask

	task automatic pick_request(output logic [1:0] req_op, output logic [ADDR_W-1:0] req_addr);
		int unsigned roll;
		int unsigned pg;
		roll     = $urandom_range(99);
		req_op   = OP_ALLOC;
		req_addr = $urandom();
		if (roll >= 45 && roll < 83 && held_pages.size() != 0) begin
			req_op   = OP_FREE;
			pg       = held_pages[$urandom_range(held_pages.size() - 1)];
			req_addr = (pg << OFF_W) | $urandom_range(PAGE_BYTES - 1);
		end else if (roll >= 83 && roll < 85) begin
			req_op = OP_INIT;
		end else if (roll >= 85 && roll < 88) begin
			req_op = OP_UNUSED;
		end else if (roll >= 88) begin
			req_op = OP_FREE;
			case ($urandom_range(3))
				0: pg = $urandom_range(MAX_PAGES - 1);
				1: begin
					pg = usable_pages();
					if (pg != 0 && $urandom_range(1) == 1)
						pg--;
				end
				2: pg = (reserved_limit() == 0) ? 0 : $urandom_range(reserved_limit() - 1);
				default: pg = MAX_PAGES;
			endcase
			// the last choice keeps the fully random address
			if (pg != MAX_PAGES)
				req_addr = (pg << OFF_W) | $urandom_range(PAGE_BYTES - 1);
		end
	endtask

	task automatic write_register(input reg_idx_e which, input logic [CFG_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= which;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (which == REG_TOTAL)
			total_reg = value;
		else
			reserved_reg = value;
	endtask

	task automatic wait_until_idle();
		while (expected_replies.size() != 0 || busy)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	always @(posedge clk) begin
		page_reply_t want;
		if (arst_n && done) begin
			if (expected_replies.size() == 0) begin
				$display("%0t: reply with none expected: addr %h status %0d count %0d",
					$time, granted_address, status, free_count);
				mismatch_count++;
			end else begin
				want = expected_replies.pop_front();
				if (granted_address !== want.addr) begin
					$display("%0t: granted_address expected %h actual %h",
						$time, want.addr, granted_address);
					mismatch_count++;
				end
				if (status !== want.st) begin
					$display("%0t: status expected %0d actual %0d", $time, want.st, status);
					mismatch_count++;
				end
				if (free_count !== want.cnt) begin
					$display("%0t: free_count expected %0d actual %0d",
						$time, want.cnt, free_count);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	initial begin
		page_reply_t      row_reply;
		logic [1:0]       r_op;
		logic [ADDR_W-1:0] r_addr;
		arst_n       <= 1'b0;
		start        <= 1'b0;
		op           <= OP_ALLOC;
		page_address <= '0;
		cfg_valid    <= 1'b0;
		cfg_index    <= REG_TOTAL;
		cfg_data     <= '0;
		total_reg    = TOTAL_RESET;
		reserved_reg = RESERVED_RESET;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			row_reply.addr = directed_rows[i].g_addr;
			row_reply.st   = directed_rows[i].g_st;
			row_reply.cnt  = directed_rows[i].g_cnt;
			send_request(directed_rows[i].op, directed_rows[i].addr,
				directed_rows[i].fixed, row_reply);
		end

		foreach (phases[p]) begin
			start <= 1'b0;
			wait_until_idle();
			write_register(REG_TOTAL, phases[p].total);
			write_register(REG_RESERVED, phases[p].reserved);
			cfg_valid  <= 1'b0;
			steady_run = phases[p].steady;
			if (phases[p].reinit)
				send_request(OP_INIT, $urandom(), 1'b0, row_reply);
			for (int n = 0; n < phases[p].items; n++) begin
				pick_request(r_op, r_addr);
				send_request(r_op, r_addr, 1'b0, row_reply);
			end
		end

		start <= 1'b0;
		while (expected_replies.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
